FILE: hw/rtl/lsst_pkg.sv
`timescale 1ns / 1ps
package lsst_pkg;

	// Default geometry limits of the row store.
	localparam int MAX_COLUMNS_DEF  = 1024;
	localparam int MAX_CHANNELS_DEF = 4;

	// The ring always holds four rows.
	localparam int STORED_ROWS = 4;
	localparam int SLOT_W      = 2;

	// Field widths of the channels.
	localparam int SAMPLE_W   = 8;
	localparam int CHAN_W     = 3;
	localparam int COLS_W     = 11;
	localparam int ROWS_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Opcodes of an input item.
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_DRAIN  = 1'b1;

	// Configuration register indices.
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLUMNS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS    = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [CHAN_W-1:0] CHANNEL_COUNT_RST = 3'd1;
	localparam logic [COLS_W-1:0] FRAME_COLUMNS_RST = 11'd640;
	localparam logic [ROWS_W-1:0] FRAME_ROWS_RST    = 16'd480;

endpackage

FILE: hw/rtl/lsst_ifs.sv
`timescale 1ns / 1ps
// Input channel: one sample or drain command per item.
interface lsst_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] sample;
	modport source (output valid, output opcode, output sample, input ready);
	modport sink (input valid, input opcode, input sample, output ready);
endinterface

// Output channel: one smoothed sample per item.
interface lsst_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] smoothed;
	logic       frame_end;
	modport source (output valid, output smoothed, output frame_end, input ready);
	modport sink (input valid, input smoothed, input frame_end, output ready);
endinterface

// Configuration write channel.
interface lsst_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/lsst_ram.sv
`timescale 1ns / 1ps
module lsst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// A read in the same cycle as a write to that entry returns the old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/laplacian_smoothing_stencil.sv
`timescale 1ns / 1ps
// Laplacian smoothing over a raster stream of 8-bit samples with up to four interleaved
// channels. Each result is the sample plus a quarter of its second difference along x and
// along y (same channel, truncated toward zero, one-sided at the frame edges), clamped to
// 0..255, and results leave in raster order, at most one per accepted item; drain items
// flush the backlog at the end of a frame. The block takes one item every clock cycle while
// the output is not stalled: the store is a ring of four rows, each kept in three copies of
// a one-read-port RAM, so that the centre sample, its two x neighbours and the same column
// of all four rows are read together in one cycle. The RAM read is registered at the edge
// that accepts the item which releases a result, and the arithmetic is registered into the
// output register once that register is free; the result is offered from there. A stalled
// output holds the input only while both the stage and the output register are full. The
// store needs no clearing after reset.
module laplacian_smoothing_stencil
	import lsst_pkg::*;
#(
	parameter int MAX_COLUMNS  = MAX_COLUMNS_DEF,
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	lsst_in_if.sink    samples,
	lsst_out_if.source results,
	lsst_cfg_if.sink   cfg
);

	localparam int ROW_SPAN = MAX_COLUMNS * MAX_CHANNELS;
	localparam int PW       = $clog2(ROW_SPAN);
	localparam int WW       = PW + 1;
	localparam int CW       = $clog2(MAX_COLUMNS + 1);
	localparam int NPORTS   = 3;

	typedef enum logic [1:0] {DY_TOP, DY_MID, DY_BOTTOM} dy_mode_t;

	// Configuration registers.
	logic [CHAN_W-1:0] channel_count_q;
	logic [COLS_W-1:0] frame_columns_q;
	logic [ROWS_W-1:0] frame_rows_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q <= CHANNEL_COUNT_RST;
			frame_columns_q <= FRAME_COLUMNS_RST;
			frame_rows_q    <= FRAME_ROWS_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_CHANNEL_COUNT: channel_count_q <= cfg.data[CHAN_W-1:0];
				REG_FRAME_COLUMNS: frame_columns_q <= cfg.data[COLS_W-1:0];
				REG_FRAME_ROWS:    frame_rows_q    <= cfg.data[ROWS_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective geometry with out-of-range settings folded in.
	logic [CHAN_W-1:0] n_eff;
	logic [CW-1:0]     cols_eff;
	logic [WW-1:0]     w;
	logic [ROWS_W-1:0] r;

	always_comb begin
		if (channel_count_q == '0) begin
			n_eff = CHAN_W'(1);
		end else if (32'(channel_count_q) > MAX_CHANNELS) begin
			n_eff = CHAN_W'(MAX_CHANNELS);
		end else begin
			n_eff = channel_count_q;
		end
		if (frame_columns_q < COLS_W'(3)) begin
			cols_eff = CW'(3);
		end else if (32'(frame_columns_q) > MAX_COLUMNS) begin
			cols_eff = CW'(MAX_COLUMNS);
		end else begin
			cols_eff = CW'(frame_columns_q);
		end
		w = WW'(32'(cols_eff) * 32'(n_eff));
		r = (frame_rows_q < ROWS_W'(3)) ? ROWS_W'(3) : frame_rows_q;
	end

	// Stream position state.
	logic [ROWS_W-1:0] wrow_q, erow_q;
	logic [PW-1:0]     wpos_q, epos_q;
	logic [SLOT_W-1:0] wslot_q, eslot_q;
	logic              behind_q;

	logic              valid_s1, out_valid_q, out_free, move_s1, accept, is_sample, we;
	logic [ROWS_W-1:0] wrow_nx, erow_nx, nr;
	logic [PW-1:0]     wpos_nx, epos_nx;
	logic [SLOT_W-1:0] wslot_nx, eslot_nx;
	logic              behind_nx, res_ready, emit, frame_end_nx;
	logic [WW-1:0]     wpos_inc, epos_inc, ie, ne, np, addr_a, addr_b;
	logic [ROWS_W:0]   wrow_inc, erow_inc;
	logic              x_first, x_last, x_central;
	dy_mode_t          dy_mode;
	logic [PW-1:0]     raddr [NPORTS];
	logic [STORED_ROWS-1:0][NPORTS-1:0] hit_nx;

	assign out_free      = !out_valid_q || results.ready;
	assign move_s1       = valid_s1 && out_free;
	assign samples.ready = !valid_s1 || move_s1;
	assign accept        = samples.valid && samples.ready;
	assign is_sample     = samples.opcode == OP_SAMPLE;
	assign we            = accept && is_sample;

	// Next write position, result readiness and the addresses of the stencil.
	always_comb begin
		wpos_inc  = {1'b0, wpos_q} + WW'(1);
		wrow_inc  = {1'b0, wrow_q} + (ROWS_W + 1)'(1);
		wpos_nx   = wpos_q;
		wrow_nx   = wrow_q;
		wslot_nx  = wslot_q;
		behind_nx = behind_q;
		if (we) begin
			if (wpos_inc >= w) begin
				wpos_nx  = '0;
				wslot_nx = wslot_q + SLOT_W'(1);
				if (wrow_inc >= {1'b0, r}) begin
					wrow_nx   = '0;
					behind_nx = 1'b1;
				end else begin
					wrow_nx = wrow_inc[ROWS_W-1:0];
				end
			end else begin
				wpos_nx = wpos_inc[PW-1:0];
			end
		end

		ie        = {1'b0, epos_q};
		ne        = WW'(n_eff);
		erow_inc  = {1'b0, erow_q} + (ROWS_W + 1)'(1);
		epos_inc  = ie + WW'(1);
		x_first   = ie < ne;
		x_last    = !x_first && (ie + ne >= w);
		x_central = !x_first && !x_last;
		if (x_first) begin
			addr_a = ie + (ne << 1);
			addr_b = ie + ne;
			np     = ie + (ne << 1);
		end else if (x_last) begin
			addr_a = ie - (ne << 1);
			addr_b = ie - ne;
			np     = ie;
		end else begin
			addr_a = ie + ne;
			addr_b = ie - ne;
			np     = ie + ne;
		end

		if (erow_q == '0) begin
			dy_mode = DY_TOP;
			nr      = ROWS_W'(2);
		end else if (erow_inc >= {1'b0, r}) begin
			dy_mode = DY_BOTTOM;
			nr      = erow_q;
		end else begin
			dy_mode = DY_MID;
			nr      = erow_inc[ROWS_W-1:0];
		end
		if (nr != erow_q) begin
			np = ie;
		end

		// A frame completed by this item puts the emit side behind at once.
		res_ready = behind_nx || (wrow_nx > nr) || (wrow_nx == nr && {1'b0, wpos_nx} > np);
		emit      = accept && res_ready;
		frame_end_nx = (erow_inc >= {1'b0, r}) && (epos_inc >= w);

		// Emit side advances when an accepted item releases a result.
		epos_nx  = epos_q;
		erow_nx  = erow_q;
		eslot_nx = eslot_q;
		if (emit) begin
			if (epos_inc >= w) begin
				epos_nx  = '0;
				eslot_nx = eslot_q + SLOT_W'(1);
				if (erow_inc >= {1'b0, r}) begin
					erow_nx   = '0;
					behind_nx = 1'b0;
				end else begin
					erow_nx = erow_inc[ROWS_W-1:0];
				end
			end else begin
				epos_nx = epos_inc[PW-1:0];
			end
		end

		raddr[0] = epos_q;
		raddr[1] = addr_a[PW-1:0];
		raddr[2] = addr_b[PW-1:0];

		// A sample stored ahead of the reads in the same step is forwarded.
		for (int k = 0; k < STORED_ROWS; k++) begin
			for (int p = 0; p < NPORTS; p++) begin
				hit_nx[k][p] = we && !behind_q && (wslot_q == SLOT_W'(k)) &&
					(wpos_q == raddr[p]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrow_q   <= '0;
			wpos_q   <= '0;
			wslot_q  <= '0;
			erow_q   <= '0;
			epos_q   <= '0;
			eslot_q  <= '0;
			behind_q <= 1'b0;
		end else if (accept) begin
			wrow_q   <= wrow_nx;
			wpos_q   <= wpos_nx;
			wslot_q  <= wslot_nx;
			erow_q   <= erow_nx;
			epos_q   <= epos_nx;
			eslot_q  <= eslot_nx;
			behind_q <= behind_nx;
		end
	end

	// Row store: four ring slots, three read copies each.
	logic [SAMPLE_W-1:0] rd [STORED_ROWS][NPORTS];

	for (genvar k = 0; k < STORED_ROWS; k++) begin : g_slot
		for (genvar p = 0; p < NPORTS; p++) begin : g_copy
			lsst_ram #(
				.WIDTH (SAMPLE_W),
				.DEPTH (ROW_SPAN)
			) u_ram (
				.clk   (clk),
				.we    (we && (wslot_q == SLOT_W'(k))),
				.waddr (wpos_q),
				.wdata (samples.sample),
				.re    (accept),
				.raddr (raddr[p]),
				.rdata (rd[k][p])
			);
		end
	end

	// Stage 1 control and forwarding data.
	logic [SLOT_W-1:0]                  slot_s1;
	logic                               central_s1, frame_end_s1;
	dy_mode_t                           dy_mode_s1;
	logic [STORED_ROWS-1:0][NPORTS-1:0] hit_s1;
	logic [SAMPLE_W-1:0]                wdata_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			slot_s1      <= eslot_q;
			central_s1   <= x_central;
			frame_end_s1 <= frame_end_nx;
			dy_mode_s1   <= dy_mode;
			hit_s1       <= hit_nx;
			wdata_s1     <= samples.sample;
		end
	end

	// Quarter of a second difference, truncated toward zero.
	function automatic logic signed [8:0] quarter(input logic signed [10:0] x);
		logic signed [10:0] b;
		b = (x < 0) ? x + 11'sd3 : x;
		return b[10:2];
	endfunction

	// Stencil arithmetic and clamp.
	logic [SAMPLE_W-1:0] col_d [STORED_ROWS];
	logic [SAMPLE_W-1:0] pa, pb, pc, ps1, ps2, pu1, pu2, xmid, ymid;
	logic [9:0]          xout, yout;
	logic signed [10:0]  dxs, dys, v;
	logic [SAMPLE_W-1:0] smoothed_nx;

	always_comb begin
		for (int k = 0; k < STORED_ROWS; k++) begin
			col_d[k] = hit_s1[k][0] ? wdata_s1 : rd[k][0];
		end
		pc  = col_d[slot_s1];
		ps1 = col_d[slot_s1 + SLOT_W'(1)];
		ps2 = col_d[slot_s1 + SLOT_W'(2)];
		pu1 = col_d[slot_s1 - SLOT_W'(1)];
		pu2 = col_d[slot_s1 - SLOT_W'(2)];
		pa  = hit_s1[slot_s1][1] ? wdata_s1 : rd[slot_s1][1];
		pb  = hit_s1[slot_s1][2] ? wdata_s1 : rd[slot_s1][2];

		xmid = central_s1 ? pc : pb;
		xout = {2'b00, pa} + {2'b00, (central_s1 ? pb : pc)};
		case (dy_mode_s1)
			DY_TOP: begin
				ymid = ps1;
				yout = {2'b00, ps2} + {2'b00, pc};
			end
			DY_BOTTOM: begin
				ymid = pu1;
				yout = {2'b00, pc} + {2'b00, pu2};
			end
			default: begin
				ymid = pc;
				yout = {2'b00, ps1} + {2'b00, pu1};
			end
		endcase
		dxs = $signed({1'b0, xout}) - $signed({2'b00, xmid, 1'b0});
		dys = $signed({1'b0, yout}) - $signed({2'b00, ymid, 1'b0});
		v   = $signed({3'b000, pc}) + 11'(quarter(dxs)) + 11'(quarter(dys));
		if (v < 0) begin
			smoothed_nx = '0;
		end else if (v > 11'sd255) begin
			smoothed_nx = '1;
		end else begin
			smoothed_nx = v[SAMPLE_W-1:0];
		end
	end

	// Output register.
	logic [SAMPLE_W-1:0] smoothed_q;
	logic                frame_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			smoothed_q  <= smoothed_nx;
			frame_end_q <= frame_end_s1;
		end
	end

	assign results.valid     = out_valid_q;
	assign results.smoothed  = smoothed_q;
	assign results.frame_end = frame_end_q;

`ifndef SYNTHESIS
	// Forwarding is only armed when the sample is stored ahead of the reads.
	a_fwd_only_current_frame: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (hit_s1 == '0 || !$past(behind_q)))
		else $error("forwarding armed while the emit side was behind");

	// A finished result moves into a free output register at once.
	a_stage_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_free) |=> results.valid)
		else $error("result lost between stage 1 and the output register");

	// The emit and write positions never leave the row store.
	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(epos_q) < ROW_SPAN && 32'(wpos_q) < ROW_SPAN)
		else $error("stream position outside the row store");

	// No item is taken while stage 1 is blocked.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_free) |-> !accept)
		else $error("item accepted over a blocked result");
`endif

endmodule
